[hdl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, field widths, character codes, opcodes and register
// indexes that the console engine and its checker share.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Screen geometry.
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);

   // Field widths of the request and response beats.
   localparam int OPCODE_W = 2;
   localparam int CHAR_W   = 8;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int CELL_W   = 16;
   localparam int ATTR_W   = 8;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = ATTR_W;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_ATTR  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK_ATTR = 1'b1;

   // Attribute that reset stores and the blank pass after reset uses.
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

   // Character codes with a meaning of their own.
   localparam logic [CHAR_W-1:0] CHR_NUL       = 8'h00;
   localparam logic [CHAR_W-1:0] CHR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHR_SPACE     = 8'h20;

   // Store addresses: end of the scroll copy, start of the bottom row, last cell.
   localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELLS - COLUMNS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

endpackage

[hdl/text_console_writer.sv]
// ----------------------------------------------------------------------------
// Text console writer
// Character console engine with a cursor and an 80 x 25 store of cells.
// ----------------------------------------------------------------------------
// How the block is used:
// A request beat on the req_ channel carries an opcode: put a character byte,
// clear the screen and home the cursor, or read one cell. Every request beat
// gives exactly one response beat on the rsp_ channel with the cell read (zero
// for anything but a read) and the cursor position after the request.
// An ordinary character, a zero byte, an idle opcode, an out-of-range read and
// a newline or backspace that does not scroll load the response register at
// the end of the execute step, and the block takes no new request before it
// is back in S_IDLE. An in-range read or a non-scrolling wrap first passes
// through S_READ or S_PUT. The cycle after acceptance is the execute step.
// A newline or a wrap past the bottom row scrolls: each of the COLUMNS*(ROWS-1)
// cells is read in S_COPY_RD and written back one row up in S_COPY_WR, then
// the bottom row is blanked one cell a cycle. A clear walks all 2000 cells,
// one a cycle. The block takes no request beat while it works.
// After reset a blank pass over every cell fills the store with spaces under
// attribute 7 before req_ready rises; configuration writes are taken during
// that pass. When the receiver stalls, the response beat holds in its
// register; one more request may be taken and worked on, and its result
// waits inside the block until the response register frees up.
// ----------------------------------------------------------------------------
module text_console_writer
   import tcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [COL_W-1:0]      req_read_column,
   input  logic [ROW_W-1:0]      req_read_row,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CELL_W-1:0]     rsp_cell_value,
   output logic [COL_W-1:0]      rsp_cursor_column,
   output logic [ROW_W-1:0]      rsp_cursor_row,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // The sequencer. S_INIT is the blank pass after reset, S_FILL the one that
   // a clear runs. Scrolling alternates S_COPY_RD and S_COPY_WR, then blanks
   // the bottom row in S_BLANK_ROW.
   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_PUT,
      S_READ,
      S_FILL,
      S_COPY_RD,
      S_COPY_WR,
      S_BLANK_ROW,
      S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic                    pend_put_ff, pend_put_in;
   logic [ATTR_W-1:0]       text_attr_ff, text_attr_in;
   logic [ATTR_W-1:0]       blank_attr_ff, blank_attr_in;

   // Captured request and the result waiting for the response register.
   opcode_type              op_ff, op_in;
   logic [CHAR_W-1:0]       chr_ff, chr_in;
   logic [COL_W-1:0]        rd_col_ff, rd_col_in;
   logic [ROW_W-1:0]        rd_row_ff, rd_row_in;
   logic [CELL_W-1:0]       cell_ff, cell_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]       rsp_cell_ff, rsp_cell_in;
   logic [COL_W-1:0]        rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]        rsp_row_ff, rsp_row_in;

   // Cell store: one write port, one read port with registered data.
   logic [CELL_W-1:0]       screen_mem [CELLS];
   logic [CELL_W-1:0]       rd_data_ff;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [ADDR_W-1:0]       mem_raddr;
   logic [CELL_W-1:0]       mem_wdata;

   logic                    finish;
   logic [COL_W-1:0]        bs_col;
   logic [ROW_W-1:0]        bs_row;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(int'(row) * COLUMNS + int'(col));
   endfunction

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_value    = rsp_cell_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;

   // Backspace steps back one cell, wrapping to the end of the row above;
   // at home it stays put.
   always_comb begin
      bs_col = col_ff;
      bs_row = row_ff;
      if (col_ff != '0) begin
         bs_col = col_ff - 1'b1;
      end else if (row_ff != '0) begin
         bs_row = row_ff - 1'b1;
         bs_col = COL_W'(COLUMNS - 1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      pend_put_in   = pend_put_ff;
      text_attr_in  = text_attr_ff;
      blank_attr_in = blank_attr_ff;
      op_in         = op_ff;
      chr_in        = chr_ff;
      rd_col_in     = rd_col_ff;
      rd_row_in     = rd_row_ff;
      cell_in       = cell_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_cell_in   = rsp_cell_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = {blank_attr_ff, CHR_SPACE};
      mem_raddr     = cell_addr(rd_row_ff, rd_col_ff);
      finish        = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_TEXT_ATTR:  text_attr_in  = csr_wdata;
            CSR_BLANK_ATTR: blank_attr_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = {RESET_ATTR, CHR_SPACE};
            if (addr_ff == CELL_LAST) begin
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               op_in     = opcode_type'(req_opcode);
               chr_in    = req_char_code;
               rd_col_in = req_read_column;
               rd_row_in = req_read_row;
               state_in  = S_EXEC;
            end
         end

         S_EXEC: begin
            cell_in = '0;
            case (op_ff)
               OP_PUT: begin
                  if (chr_ff == CHR_NUL) begin
                     finish = 1'b1;
                  end else if (chr_ff == CHR_NEWLINE) begin
                     col_in = '0;
                     if (row_ff == ROW_W'(ROWS - 1)) begin
                        addr_in     = '0;
                        pend_put_in = 1'b0;
                        state_in    = S_COPY_RD;
                     end else begin
                        row_in = row_ff + 1'b1;
                        finish = 1'b1;
                     end
                  end else if (chr_ff == CHR_BACKSPACE) begin
                     col_in    = bs_col;
                     row_in    = bs_row;
                     mem_we    = 1'b1;
                     mem_waddr = cell_addr(bs_row, bs_col);
                     mem_wdata = {text_attr_ff, CHR_SPACE};
                     finish    = 1'b1;
                  end else if (col_ff >= COL_W'(COLUMNS)) begin
                     // Past the line end: wrap first, scrolling if needed,
                     // then write the character in S_PUT.
                     col_in = '0;
                     if (row_ff == ROW_W'(ROWS - 1)) begin
                        addr_in     = '0;
                        pend_put_in = 1'b1;
                        state_in    = S_COPY_RD;
                     end else begin
                        row_in   = row_ff + 1'b1;
                        state_in = S_PUT;
                     end
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = cell_addr(row_ff, col_ff);
                     mem_wdata = {text_attr_ff, chr_ff};
                     col_in    = col_ff + 1'b1;
                     finish    = 1'b1;
                  end
               end
               OP_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  addr_in  = '0;
                  state_in = S_FILL;
               end
               OP_READ: begin
                  if ((rd_col_ff < COL_W'(COLUMNS)) && (rd_row_ff < ROW_W'(ROWS))) begin
                     state_in = S_READ;
                  end else begin
                     finish = 1'b1;
                  end
               end
               default: finish = 1'b1;
            endcase
         end

         S_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(row_ff, col_ff);
            mem_wdata = {text_attr_ff, chr_ff};
            col_in    = col_ff + 1'b1;
            cell_in   = '0;
            finish    = 1'b1;
         end

         S_READ: begin
            cell_in = rd_data_ff;
            finish  = 1'b1;
         end

         S_FILL: begin
            mem_we = 1'b1;
            if (addr_ff == CELL_LAST) begin
               finish = 1'b1;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         S_COPY_RD: begin
            mem_raddr = addr_ff + ADDR_W'(COLUMNS);
            state_in  = S_COPY_WR;
         end

         S_COPY_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff;
            addr_in   = addr_ff + 1'b1;
            if (addr_ff == COPY_LAST) begin
               state_in = S_BLANK_ROW;
            end else begin
               state_in = S_COPY_RD;
            end
         end

         S_BLANK_ROW: begin
            mem_we = 1'b1;
            if (addr_ff == CELL_LAST) begin
               if (pend_put_ff) begin
                  state_in = S_PUT;
               end else begin
                  finish = 1'b1;
               end
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         S_DONE: begin
            finish = 1'b1;
         end

         default: state_in = S_IDLE;
      endcase

      // Hand the result to the response register, or park it while the
      // receiver still holds the previous beat.
      if (finish) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_in = 1'b1;
            rsp_cell_in  = cell_in;
            rsp_col_in   = col_in;
            rsp_row_in   = row_in;
            state_in     = S_IDLE;
         end else begin
            state_in = S_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         addr_ff       <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         pend_put_ff   <= 1'b0;
         text_attr_ff  <= RESET_ATTR;
         blank_attr_ff <= RESET_ATTR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         pend_put_ff   <= pend_put_in;
         text_attr_ff  <= text_attr_in;
         blank_attr_ff <= blank_attr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff       <= op_in;
      chr_ff      <= chr_in;
      rd_col_ff   <= rd_col_in;
      rd_row_ff   <= rd_row_in;
      cell_ff     <= cell_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= screen_mem[mem_raddr];
   end

endmodule

[hdl/text_console_writer_checker.sv]
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level assertions on the console engine, bound to the top level.
// ----------------------------------------------------------------------------
module text_console_writer_checker
   import tcw_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [CELL_W-1:0]     rsp_cell_value,
   input logic [COL_W-1:0]      rsp_cursor_column,
   input logic [ROW_W-1:0]      rsp_cursor_row
);

   // A stalled response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_value)
         && $stable(rsp_cursor_column) && $stable(rsp_cursor_row))
      else $error("response beat changed while stalled");

   // The cursor never leaves the screen; the column may sit one past the end.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_column <= COL_W'(COLUMNS))
         && (rsp_cursor_row < ROW_W'(ROWS)))
      else $error("cursor out of range");

   // Every request passes through the execute step with the input closed.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken in back-to-back cycles");

   // Reset empties the response register and starts the blank pass.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block not quiet after reset");

endmodule

bind text_console_writer text_console_writer_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_cell_value    (rsp_cell_value),
   .rsp_cursor_column (rsp_cursor_column),
   .rsp_cursor_row    (rsp_cursor_row)
);

[tb/sv/text_console_writer_tb.sv]
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives character, clear and read request beats into the console engine and
// checks every response beat against a cycle-free model of the screen store
// and cursor, under several attribute settings and idle patterns.
// ----------------------------------------------------------------------------
module text_console_writer_tb
   import tcw_pkg::*;
;

   // A stall longer than this with no beat on either channel ends the run.
   // The slowest legal gap is a scroll behind a long receiver hold-off, so
   // this leaves plenty of margin.
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS     = 200;
   localparam int DIRECTED_COUNT  = 25;

   // One response beat: the cell read and the cursor after the request.
   typedef struct packed {
      logic [CELL_W-1:0] cell_data;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
   } console_beat_type;

   // One row of the directed table. When has_value is set, the response is
   // typed in by hand; otherwise the screen model supplies it.
   typedef struct {
      opcode_type        op;
      logic [CHAR_W-1:0] ch;
      logic [COL_W-1:0]  rd_col;
      logic [ROW_W-1:0]  rd_row;
      bit                has_value;
      logic [CELL_W-1:0] cell_data;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OPCODE_W-1:0]   req_opcode = OP_NONE;
   logic [CHAR_W-1:0]     req_char_code = '0;
   logic [COL_W-1:0]      req_read_column = '0;
   logic [ROW_W-1:0]      req_read_row = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CELL_W-1:0]     rsp_cell_value;
   logic [COL_W-1:0]      rsp_cursor_column;
   logic [ROW_W-1:0]      rsp_cursor_row;

   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TEXT_ATTR;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Screen model: store, cursor and attribute registers as the block should
   // hold them after every accepted request beat.
   logic [CELL_W-1:0]     screen_model [CELLS];
   int                    model_col;
   int                    model_row;
   logic [ATTR_W-1:0]     model_text_attr;
   logic [ATTR_W-1:0]     model_blank_attr;

   // Responses still owed by the block, oldest first.
   console_beat_type      owed_beats [$];

   // Idle control. The sender's rate is only read by the stimulus process;
   // the receiver's rate and the long hold-off request cross processes.
   int                    send_idle_pct = 19;
   int                    recv_idle_pct = 76;
   logic                  rsp_hold_go = 1'b0;
   logic                  rsp_hold_done;
   int                    rsp_hold_left;

   int                    quiet_cycles = 0;
   int                    mismatch_count = 0;
   int                    checked_beats = 0;
   int                    useful_items = 0;
   int                    read_count = 0;
   int                    clear_count = 0;
   int                    scroll_count = 0;
   int                    wrap_count = 0;
   int                    csr_settings = 0;

   // Hand-checked opening sequence: reset contents, out-of-range reads, the
   // unused opcode, a zero byte, backspace wrapping to the previous row, a
   // character past the line end, a clear and backspace at home.
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{OP_READ,  8'h00,         7'd0,   5'd0,  1'b1, 16'h0720, 7'd0,  5'd0},
      '{OP_READ,  8'h00,         7'd79,  5'd24, 1'b1, 16'h0720, 7'd0,  5'd0},
      '{OP_READ,  8'h00,         7'd80,  5'd0,  1'b1, 16'h0000, 7'd0,  5'd0},
      '{OP_READ,  8'h00,         7'd127, 5'd31, 1'b1, 16'h0000, 7'd0,  5'd0},
      '{OP_READ,  8'h00,         7'd0,   5'd25, 1'b1, 16'h0000, 7'd0,  5'd0},
      '{OP_NONE,  8'hFF,         7'd127, 5'd31, 1'b1, 16'h0000, 7'd0,  5'd0},
      '{OP_PUT,   CHR_NUL,       7'd0,   5'd0,  1'b1, 16'h0000, 7'd0,  5'd0},
      '{OP_PUT,   8'h41,         7'd0,   5'd0,  1'b1, 16'h0000, 7'd1,  5'd0},
      '{OP_PUT,   8'hFF,         7'd0,   5'd0,  1'b1, 16'h0000, 7'd2,  5'd0},
      '{OP_READ,  8'h00,         7'd1,   5'd0,  1'b1, 16'h07FF, 7'd2,  5'd0},
      '{OP_PUT,   CHR_BACKSPACE, 7'd0,   5'd0,  1'b1, 16'h0000, 7'd1,  5'd0},
      '{OP_READ,  8'h00,         7'd1,   5'd0,  1'b1, 16'h0720, 7'd1,  5'd0},
      '{OP_PUT,   CHR_NEWLINE,   7'd0,   5'd0,  1'b1, 16'h0000, 7'd0,  5'd1},
      '{OP_PUT,   CHR_BACKSPACE, 7'd0,   5'd0,  1'b1, 16'h0000, 7'd79, 5'd0},
      '{OP_READ,  8'h00,         7'd79,  5'd0,  1'b1, 16'h0720, 7'd79, 5'd0},
      '{OP_PUT,   8'h80,         7'd0,   5'd0,  1'b1, 16'h0000, 7'd80, 5'd0},
      '{OP_PUT,   8'h7A,         7'd0,   5'd0,  1'b1, 16'h0000, 7'd1,  5'd1},
      '{OP_READ,  8'h00,         7'd0,   5'd1,  1'b1, 16'h077A, 7'd1,  5'd1},
      '{OP_PUT,   CHR_NEWLINE,   7'd0,   5'd0,  1'b1, 16'h0000, 7'd0,  5'd2},
      '{OP_PUT,   8'h55,         7'd3,   5'd3,  1'b0, 16'h0000, 7'd0,  5'd0},
      '{OP_CLEAR, 8'h00,         7'd0,   5'd0,  1'b1, 16'h0000, 7'd0,  5'd0},
      '{OP_PUT,   CHR_BACKSPACE, 7'd0,   5'd0,  1'b1, 16'h0000, 7'd0,  5'd0},
      '{OP_READ,  8'h00,         7'd0,   5'd0,  1'b1, 16'h0720, 7'd0,  5'd0},
      '{OP_PUT,   8'h01,         7'd0,   5'd0,  1'b0, 16'h0000, 7'd0,  5'd0},
      '{OP_READ,  8'h00,         7'd0,   5'd0,  1'b0, 16'h0000, 7'd0,  5'd0}
   };

   text_console_writer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_char_code     (req_char_code),
      .req_read_column   (req_read_column),
      .req_read_row      (req_read_row),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cell_value    (rsp_cell_value),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Screen model
   // ------------------------------------------------------------------------

   function automatic void blank_screen_model();
      for (int i = 0; i < CELLS; i++)
         screen_model[i] = {model_blank_attr, CHR_SPACE};
   endfunction

   // Home the column and move down a row. Past the bottom row every line
   // moves up one and the bottom row is blanked with the blank attribute.
   function automatic void advance_line();
      model_col = 0;
      model_row = model_row + 1;
      if (model_row >= ROWS) begin
         for (int i = 0; i < CELLS - COLUMNS; i++)
            screen_model[i] = screen_model[i + COLUMNS];
         for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen_model[i] = {model_blank_attr, CHR_SPACE};
         model_row = ROWS - 1;
         scroll_count++;
      end
   endfunction

   function automatic void store_cell(logic [CHAR_W-1:0] ch);
      if (model_col < COLUMNS)
         screen_model[model_row * COLUMNS + model_col] = {model_text_attr, ch};
   endfunction

   // Applies one request beat to the model and returns the response it owes.
   function automatic console_beat_type predict_console(opcode_type op,
         logic [CHAR_W-1:0] ch, logic [COL_W-1:0] rd_col, logic [ROW_W-1:0] rd_row);
      console_beat_type beat;
      beat.cell_data = '0;
      case (op)
         OP_PUT: begin
            if (ch == CHR_NEWLINE) begin
               advance_line();
            end else if (ch == CHR_BACKSPACE) begin
               // Backspace at home stays put but still blanks the home cell.
               if (model_col > 0) begin
                  model_col = model_col - 1;
               end else if (model_row > 0) begin
                  model_row = model_row - 1;
                  model_col = COLUMNS - 1;
               end
               store_cell(CHR_SPACE);
            end else if (ch != CHR_NUL) begin
               // A cursor parked past the line end wraps before the write.
               if (model_col >= COLUMNS) begin
                  advance_line();
                  wrap_count++;
               end
               store_cell(ch);
               model_col = model_col + 1;
            end
         end
         OP_CLEAR: begin
            blank_screen_model();
            model_col = 0;
            model_row = 0;
            clear_count++;
         end
         OP_READ: begin
            read_count++;
            if (rd_col < COLUMNS && rd_row < ROWS)
               beat.cell_data = screen_model[int'(rd_row) * COLUMNS + int'(rd_col)];
         end
         default: ;
      endcase
      beat.column = COL_W'(model_col);
      beat.row    = ROW_W'(model_row);
      return beat;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offers one request beat, holds it until accepted and records the
   // response owed. A hand-typed response replaces the model's when given.
   task automatic send_request(opcode_type op, logic [CHAR_W-1:0] ch,
         logic [COL_W-1:0] rd_col, logic [ROW_W-1:0] rd_row,
         bit has_value, console_beat_type typed_beat);
      console_beat_type beat;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_char_code   <= ch;
      req_read_column <= rd_col;
      req_read_row    <= rd_row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // The beat was taken at this edge.
      beat = predict_console(op, ch, rd_col, rd_row);
      owed_beats.push_back(has_value ? typed_beat : beat);
      if (!(op == OP_NONE || (op == OP_PUT && ch == CHR_NUL)))
         useful_items++;
   endtask

   // Stops offering and waits until every owed response is in and the
   // block is ready again, so that nothing is still in progress.
   task automatic wait_console_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_beats.size() != 0 || !req_ready) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // The write enable drops for a cycle after each write, so two writes in
   // a row never assign it twice in one step.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_TEXT_ATTR)
         model_text_attr = data;
      else
         model_blank_attr = data;
   endtask

   // One random burst. Most bursts are runs of text, newlines or reads aimed
   // near the cursor, so that wraps, scrolls and fresh cells get observed;
   // the rest is single noise beats.
   task automatic random_burst();
      int                kind;
      int                count;
      int                pick;
      int                near_row;
      logic [CHAR_W-1:0] ch;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         count = $urandom_range(1, 90);
         for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
               ch = CHR_BACKSPACE;
            else if (pick < 7)
               ch = CHR_NEWLINE;
            else
               ch = CHAR_W'($urandom_range(1, 255));
            send_request(OP_PUT, ch, COL_W'($urandom), ROW_W'($urandom), 1'b0, '0);
         end
         if ($urandom_range(0, 1) == 1)
            send_request(OP_PUT, CHR_NEWLINE, '0, '0, 1'b0, '0);
      end else if (kind < 70) begin
         count = $urandom_range(1, 8);
         for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               near_row = model_row - ((model_row > 0) ? $urandom_range(0, 1) : 0);
               send_request(OP_READ, CHAR_W'($urandom), COL_W'($urandom_range(0, 79)),
                            ROW_W'(near_row), 1'b0, '0);
            end else if (pick < 9) begin
               send_request(OP_READ, CHAR_W'($urandom), COL_W'($urandom_range(0, 79)),
                            ROW_W'($urandom_range(0, 24)), 1'b0, '0);
            end else begin
               send_request(OP_READ, CHAR_W'($urandom), COL_W'($urandom_range(0, 127)),
                            ROW_W'($urandom_range(0, 31)), 1'b0, '0);
            end
         end
      end else if (kind < 82) begin
         count = $urandom_range(2, 12);
         for (int i = 0; i < count; i++)
            send_request(OP_PUT, CHR_NEWLINE, COL_W'($urandom), ROW_W'($urandom), 1'b0, '0);
      end else begin
         case ($urandom_range(0, 4))
            0: send_request(OP_PUT, CHR_NUL, COL_W'($urandom), ROW_W'($urandom), 1'b0, '0);
            1: send_request(OP_NONE, CHAR_W'($urandom), COL_W'($urandom),
                            ROW_W'($urandom), 1'b0, '0);
            2: send_request(OP_CLEAR, CHAR_W'($urandom), COL_W'($urandom),
                            ROW_W'($urandom), 1'b0, '0);
            3: send_request(OP_PUT, CHAR_W'($urandom), COL_W'($urandom),
                            ROW_W'($urandom), 1'b0, '0);
            default: send_request(OP_READ, CHAR_W'($urandom), COL_W'($urandom),
                                  ROW_W'($urandom), 1'b0, '0);
         endcase
      end
   endtask

   // One random phase. It opens with a clear so that the new blank attribute
   // shows up in the store, then runs bursts until enough beats went in.
   // Optionally the receiver is told once to hold off for a long stretch, or
   // the sender pauses once until the block has drained.
   task automatic run_random_phase(int send_pct, int recv_pct, bit long_hold, bit drain_pause);
      int start;
      bit hold_asked;
      bit paused;
      start      = useful_items;
      hold_asked = 1'b0;
      paused     = 1'b0;
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
      send_request(OP_CLEAR, '0, '0, '0, 1'b0, '0);
      while (useful_items - start < PHASE_ITEMS) begin
         if (long_hold && !hold_asked && useful_items - start >= PHASE_ITEMS / 4) begin
            rsp_hold_go <= 1'b1;
            hold_asked = 1'b1;
         end
         if (drain_pause && !paused && useful_items - start >= PHASE_ITEMS / 2) begin
            wait_console_idle();
            paused = 1'b1;
         end
         random_burst();
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // The receiver drops ready at random at the phase's rate. Once asked, it
   // holds off for a long stretch on its own count, so the block fills up
   // and has to stall its request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left <= 0;
         rsp_hold_done <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (rsp_hold_go && !rsp_hold_done) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left <= RSP_HOLD_CYCLES;
         rsp_hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Every response beat is checked against the oldest owed response.
   always @(posedge clock) begin
      console_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_beats.size() == 0) begin
            $display("%0t: response beat with none owed: cell %h col %0d row %0d",
                     $time, rsp_cell_value, rsp_cursor_column, rsp_cursor_row);
            mismatch_count++;
         end else begin
            want = owed_beats.pop_front();
            checked_beats++;
            if (rsp_cell_value !== want.cell_data || rsp_cursor_column !== want.column ||
                rsp_cursor_row !== want.row) begin
               $display("%0t: mismatch: expected cell %h col %0d row %0d, got cell %h col %0d row %0d",
                        $time, want.cell_data, want.column, want.row,
                        rsp_cell_value, rsp_cursor_column, rsp_cursor_row);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: counts cycles with no beat on either channel. The clearing
   // pass after reset and every scroll count against it, hence the margin.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d responses still owed",
                  $time, quiet_cycles, owed_beats.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------

   initial begin
      model_text_attr  = RESET_ATTR;
      model_blank_attr = RESET_ATTR;
      model_col        = 0;
      model_row        = 0;
      blank_screen_model();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table under reset attributes. Beats are offered at once;
      // the block takes the first only after its clearing pass.
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].rd_col,
                      directed_rows[i].rd_row, directed_rows[i].has_value,
                      '{directed_rows[i].cell_data, directed_rows[i].column,
                        directed_rows[i].row});
      end
      wait_console_idle();

      // Extreme attributes first, swapped next, then a random pair. The
      // receiver's long hold-off falls in the first phase, the sender's
      // drain pause in the last.
      write_csr(CSR_TEXT_ATTR, 8'hFF);
      write_csr(CSR_BLANK_ATTR, 8'h00);
      csr_settings++;
      run_random_phase(19, 76, 1'b1, 1'b0);
      wait_console_idle();

      write_csr(CSR_TEXT_ATTR, 8'h00);
      write_csr(CSR_BLANK_ATTR, 8'hFF);
      csr_settings++;
      run_random_phase(76, 19, 1'b0, 1'b0);
      wait_console_idle();

      write_csr(CSR_TEXT_ATTR, CSR_DATA_W'($urandom_range(0, 255)));
      write_csr(CSR_BLANK_ATTR, CSR_DATA_W'($urandom_range(0, 255)));
      csr_settings++;
      run_random_phase(0, 0, 1'b0, 1'b1);

      // Drain, then keep the clock running so that any stray beat would show.
      wait_console_idle();
      repeat (20) @(posedge clock);

      $display("Run covered %0d request beats and checked %0d responses: %0d reads,",
               useful_items, checked_beats, read_count);
      $display("%0d clears, %0d scrolls, %0d line wraps, %0d attribute settings after reset",
               clear_count, scroll_count, wrap_count, csr_settings);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
